// ===== sv/ac3bp_pkg.sv =====
package ac3bp_pkg;

  // Input word: one frame byte with its framing flags
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
    logic       preview;
  } in_t;

  // Output word: one burst byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_burst;
  } out_t;

  // Work passed from the front end to the back end.
  // Header job: bytes[0..5] are the first six frame bytes.
  // Pair job: bytes[0] is the odd byte, bytes[1] the held even byte.
  typedef struct packed {
    logic            is_head;
    logic            last;
    logic [10:0]     len_words;
    logic [5:0][7:0] bytes;
  } job_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic not_empty;
  } fifo_stat_t;

  localparam int unsigned HEAD_LEN   = 6;
  localparam int unsigned FIFO_DEPTH = 4;

  // Burst preamble
  localparam logic [7:0] SYNC_PA_LO    = 8'h72;
  localparam logic [7:0] SYNC_PA_HI    = 8'hf8;
  localparam logic [7:0] SYNC_PB_LO    = 8'h1f;
  localparam logic [7:0] SYNC_PB_HI    = 8'h4e;
  localparam logic [7:0] DATA_TYPE_AC3 = 8'h01;

  localparam logic [1:0] FSCOD_RSVD = 2'd3;
  localparam logic [5:0] NUM_FRMSIZ = 6'd38;

  // Frame size in 16-bit words, by frmsizecod and fscod (48, 44.1, 32 kHz)
  localparam logic [10:0] SIZE_TBL [38][3] = '{
    '{11'd64,   11'd69,   11'd96},   '{11'd64,   11'd70,   11'd96},
    '{11'd80,   11'd87,   11'd120},  '{11'd80,   11'd88,   11'd120},
    '{11'd96,   11'd104,  11'd144},  '{11'd96,   11'd105,  11'd144},
    '{11'd112,  11'd121,  11'd168},  '{11'd112,  11'd122,  11'd168},
    '{11'd128,  11'd139,  11'd192},  '{11'd128,  11'd140,  11'd192},
    '{11'd160,  11'd174,  11'd240},  '{11'd160,  11'd175,  11'd240},
    '{11'd192,  11'd208,  11'd288},  '{11'd192,  11'd209,  11'd288},
    '{11'd224,  11'd243,  11'd336},  '{11'd224,  11'd244,  11'd336},
    '{11'd256,  11'd278,  11'd384},  '{11'd256,  11'd279,  11'd384},
    '{11'd320,  11'd348,  11'd480},  '{11'd320,  11'd349,  11'd480},
    '{11'd384,  11'd417,  11'd576},  '{11'd384,  11'd418,  11'd576},
    '{11'd448,  11'd487,  11'd672},  '{11'd448,  11'd488,  11'd672},
    '{11'd512,  11'd557,  11'd768},  '{11'd512,  11'd558,  11'd768},
    '{11'd640,  11'd696,  11'd960},  '{11'd640,  11'd697,  11'd960},
    '{11'd768,  11'd835,  11'd1152}, '{11'd768,  11'd836,  11'd1152},
    '{11'd896,  11'd975,  11'd1344}, '{11'd896,  11'd976,  11'd1344},
    '{11'd1024, 11'd1114, 11'd1536}, '{11'd1024, 11'd1115, 11'd1536},
    '{11'd1152, 11'd1253, 11'd1728}, '{11'd1152, 11'd1254, 11'd1728},
    '{11'd1280, 11'd1393, 11'd1920}, '{11'd1280, 11'd1394, 11'd1920}
  };

  // Look up frame words from the fscod/frmsizecod byte; reserved codes give 0
  function automatic logic [10:0] size_words(input logic [7:0] b4);
    logic [1:0] fs;
    logic [5:0] code;
    fs   = b4[7:6];
    code = b4[5:0];
    if (fs == FSCOD_RSVD || code >= NUM_FRMSIZ) begin
      return 11'd0;
    end
    return SIZE_TBL[code][fs];
  endfunction

endpackage

// ===== sv/ac3bp_front.sv =====
module ac3bp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ac3bp_pkg::in_t        in_data,
  input  ac3bp_pkg::fifo_stat_t stat,
  output logic                  push,
  output ac3bp_pkg::job_t       job
);

  localparam logic [11:0] CNT_MAX  = 12'hfff;
  localparam logic [11:0] HEAD_END = 12'(ac3bp_pkg::HEAD_LEN - 1);
  localparam logic [11:0] HEAD_CNT = 12'(ac3bp_pkg::HEAD_LEN);

  logic [11:0] byte_count_r, byte_count_nxt;
  logic [10:0] len_words_r, len_words_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        in_frame_r, in_frame_nxt;
  logic        suppress_r, suppress_nxt;
  logic [7:0]  head_r [5];

  logic        acc;
  logic        cur_in;
  logic        cur_sup;
  logic [11:0] cnt;
  logic [11:0] total;
  logic [10:0] lw;
  logic [11:0] lw_total;
  logic [7:0]  b;

  assign in_ready = !stat.full;
  assign acc      = in_valid && in_ready;
  assign b        = in_data.frame_byte;

  // Frame start overrides the running frame state
  assign cur_in   = in_data.frame_start || in_frame_r;
  assign cur_sup  = in_data.frame_start ? in_data.preview : suppress_r;
  assign cnt      = in_data.frame_start ? 12'd0 : byte_count_r;
  assign total    = {len_words_r, 1'b0};
  assign lw       = ac3bp_pkg::size_words(head_r[4]);
  assign lw_total = {lw, 1'b0};

  // Classify the word and build the job for the back end
  always_comb begin
    byte_count_nxt = byte_count_r;
    len_words_nxt  = len_words_r;
    held_nxt       = held_r;
    in_frame_nxt   = in_frame_r;
    suppress_nxt   = suppress_r;
    push           = 1'b0;
    job            = '0;
    if (acc) begin
      in_frame_nxt = cur_in;
      suppress_nxt = cur_sup;
      if (in_data.frame_start) begin
        byte_count_nxt = 12'd0;
      end
      if (cur_in) begin
        if (cnt < HEAD_CNT) begin
          if (cnt == HEAD_END) begin
            len_words_nxt = lw;
            job.is_head   = 1'b1;
            job.len_words = lw;
            job.bytes     = {b, head_r[4], head_r[3], head_r[2], head_r[1], head_r[0]};
            push          = !cur_sup;
            if (lw_total <= HEAD_CNT) begin
              in_frame_nxt = 1'b0;
            end
          end
        end else if (cnt < total) begin
          if (!cnt[0]) begin
            held_nxt = b;
          end else begin
            job.bytes[0] = b;
            job.bytes[1] = held_r;
            job.last     = ((cnt + 12'd1) == total);
            push         = !cur_sup;
            if ((cnt + 12'd1) == total) begin
              in_frame_nxt = 1'b0;
            end
          end
        end else begin
          in_frame_nxt = 1'b0;
        end
        byte_count_nxt = (cnt < CNT_MAX) ? cnt + 12'd1 : cnt;
      end
    end
  end

  // Hold the first five frame bytes; byte five is used straight from the input
  always_ff @(posedge clk) begin
    if (acc && cur_in && cnt < HEAD_END) begin
      head_r[cnt[2:0]] <= b;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      len_words_r  <= '0;
      in_frame_r   <= 1'b0;
      suppress_r   <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      len_words_r  <= len_words_nxt;
      in_frame_r   <= in_frame_nxt;
      suppress_r   <= suppress_nxt;
    end
  end

endmodule

// ===== sv/ac3bp_fifo.sv =====
module ac3bp_fifo #(
  parameter int unsigned DEPTH = ac3bp_pkg::FIFO_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ac3bp_pkg::job_t       push_job,
  input  logic                  pop,
  output ac3bp_pkg::job_t       head_job,
  output ac3bp_pkg::fifo_stat_t stat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  ac3bp_pkg::job_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign stat.full      = (count_r == CNT_FULL);
  assign stat.not_empty = (count_r != '0);
  assign do_push        = push && !stat.full;
  assign do_pop         = pop && stat.not_empty;
  assign head_job       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// ===== sv/ac3bp_back.sv =====
module ac3bp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ac3bp_pkg::job_t       job,
  input  ac3bp_pkg::fifo_stat_t stat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ac3bp_pkg::out_t       out_data
);

  localparam logic [3:0] HDR_LEN_HI = 4'd7;
  localparam logic [3:0] JOB_END    = 4'd13;

  logic [3:0]      pos_r, pos_nxt;
  logic            out_valid_r;
  ac3bp_pkg::out_t out_r, sel;
  logic            load;
  logic            job_done;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign load      = stat.not_empty && (!out_valid_r || out_ready);
  assign pop       = load && job_done;

  // Pick the byte at the current position of the job
  always_comb begin
    sel.last_of_burst = 1'b0;
    sel.out_byte      = 8'h00;
    if (job.is_head) begin
      case (pos_r)
        4'd0:  sel.out_byte = ac3bp_pkg::SYNC_PA_LO;
        4'd1:  sel.out_byte = ac3bp_pkg::SYNC_PA_HI;
        4'd2:  sel.out_byte = ac3bp_pkg::SYNC_PB_LO;
        4'd3:  sel.out_byte = ac3bp_pkg::SYNC_PB_HI;
        4'd4:  sel.out_byte = ac3bp_pkg::DATA_TYPE_AC3;
        4'd5:  sel.out_byte = {5'd0, job.bytes[5][2:0]};
        4'd6:  sel.out_byte = {job.len_words[3:0], 4'd0};
        4'd7:  begin
          sel.out_byte      = {1'b0, job.len_words[10:4]};
          sel.last_of_burst = (job.len_words == '0);
        end
        4'd8:  sel.out_byte = job.bytes[1];
        4'd9:  sel.out_byte = job.bytes[0];
        4'd10: sel.out_byte = job.bytes[3];
        4'd11: sel.out_byte = job.bytes[2];
        4'd12: sel.out_byte = job.bytes[5];
        4'd13: sel.out_byte = job.bytes[4];
        default: sel.out_byte = 8'h00;
      endcase
    end else if (pos_r[0]) begin
      sel.out_byte      = job.bytes[1];
      sel.last_of_burst = job.last;
    end else begin
      sel.out_byte = job.bytes[0];
    end
  end

  // Detect the final word of the job
  always_comb begin
    if (job.is_head) begin
      job_done = (pos_r == JOB_END) || (pos_r == HDR_LEN_HI && job.len_words == '0);
    end else begin
      job_done = pos_r[0];
    end
    pos_nxt = pos_r;
    if (load) begin
      pos_nxt = job_done ? 4'd0 : pos_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/ac3_spdif_burst_packer_unit.sv =====
// Channel | Ports                               | Word
// input   | in_valid, in_ready, in_data         | ac3bp_pkg::in_t (frame byte, flags)
// output  | out_valid, out_ready, out_data      | ac3bp_pkg::out_t (burst byte, last)
//
// One input word is taken per cycle while the job queue has room.
// Unless out_ready stalls it or the queue is empty, the back end sends one
// burst byte per cycle: 14 for the header job at frame byte 5 (8 if the frame
// size code is reserved), 2 per odd payload byte. Jobs pass through the job
// queue, and burst bytes leave from the registered output.
// Reset (rst_n low at a clock edge) empties the queue and clears frame state.
// Either side may stall; the queue of FIFO_DEPTH jobs decouples them.
module ac3_spdif_burst_packer_unit #(
  parameter int unsigned FIFO_DEPTH = ac3bp_pkg::FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ac3bp_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ac3bp_pkg::out_t out_data
);

  ac3bp_pkg::job_t       push_job, head_job;
  ac3bp_pkg::fifo_stat_t stat;
  logic                  push, pop;

  ac3bp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .stat     (stat),
    .push     (push),
    .job      (push_job)
  );

  ac3bp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (stat)
  );

  ac3bp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (head_job),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
